FILE: hdl/sma_pkg.sv
`default_nettype none

package sma_pkg;

    localparam int DATA_W    = 64;
    localparam int CMD_W     = 4;
    localparam int STATUS_W  = 2;
    localparam int DEPTH_W   = 11;
    localparam int STEP_W    = 6;
    localparam int S_FIELD_W = CMD_W + DATA_W;
    localparam int S_TDATA_W = ((S_FIELD_W + 7) / 8) * 8;
    localparam int M_FIELD_W = STATUS_W + 1 + DATA_W + DATA_W + DEPTH_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - M_FIELD_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH = 4'd0,
        CMD_ADD  = 4'd1,
        CMD_SUB  = 4'd2,
        CMD_MUL  = 4'd3,
        CMD_DIV  = 4'd4,
        CMD_MOD  = 4'd5,
        CMD_DUP  = 4'd6,
        CMD_DROP = 4'd7,
        CMD_SWAP = 4'd8,
        CMD_EQ   = 4'd9,
        CMD_NEQ  = 4'd10,
        CMD_EMIT = 4'd11
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_UNDER = 2'd1,
        STAT_OVER  = 2'd2,
        STAT_DIVZ  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_ITER,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic start;
        logic is_div;
    } iter_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } iter_stat_t;

endpackage

`default_nettype wire

FILE: hdl/stack_machine_alu.sv
`default_nettype none

// 64-bit operand stack machine. each input beat carries one instruction (push, add, sub,
// mul, div, mod, dup, drop, swap, eq, neq, emit) and produces exactly one output beat
// with the status, the emitted value if any, the new top of stack and the new depth.
// the top of stack lives in a register and the entries below it in a single-port-write
// memory of STACK_DEPTH words; a failing instruction (underflow, overflow, divide by
// zero) leaves the stack untouched. stack, compare, add and sub instructions pass through
// accept, execute with the one memory read, and result load; mul, div and mod run through
// one shared 64-step shift/add-subtract unit, one bit a cycle, between execute and result
// load. the block takes one instruction at a time; s_tready is high only while idle, and
// a finished result may wait in the output register while the next beat is taken.

module stack_machine_alu #(
    parameter int STACK_DEPTH = 1024
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // s_tdata: cmd [3:0], operand_value [67:4], zero pad [71:68]
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [sma_pkg::S_TDATA_W-1:0]   s_tdata,
    // m_tdata: status [1:0], emit_valid [2], emitted_value [66:3], top_value [130:67],
    //          depth [141:131], zero pad [143:142]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sma_pkg::M_TDATA_W-1:0]   m_tdata
);
    import sma_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    // sequencer and stack state
    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [DATA_W-1:0] top_reg, top_next;

    // current instruction and its result fields
    cmd_t              cmd_reg, cmd_next;
    logic [DATA_W-1:0] val_reg, val_next;
    status_t           status_reg, status_next;
    logic              emit_valid_reg, emit_valid_next;
    logic [DATA_W-1:0] emitted_reg, emitted_next;

    // output register
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic              s_accept;
    logic              out_load;
    logic              empty, below_two, full, top_zero;
    logic              iter_go;

    logic              mem_wr_en, mem_rd_en;
    logic [AW-1:0]     mem_wr_addr, mem_rd_addr;
    logic [DATA_W-1:0] mem_wr_data, mem_rd_data;

    iter_ctrl_t        iter_ctrl;
    iter_stat_t        iter_stat;
    logic [DATA_W-1:0] iter_acc, iter_quot;

    assign s_accept  = s_tvalid && s_tready;
    assign empty     = (count_reg == '0);
    assign below_two = empty || (count_reg == CW'(1));
    assign full      = (count_reg == CW'(STACK_DEPTH));
    assign top_zero  = (top_reg == '0);
    assign out_load  = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    // long operations hand over to the shared unit only when all checks pass
    always_comb begin
        iter_go = 1'b0;
        if (state_reg == ST_EXEC && !below_two) begin
            unique case (cmd_reg) inside
                CMD_MUL:          iter_go = 1'b1;
                CMD_DIV, CMD_MOD: iter_go = !top_zero;
                default:          iter_go = 1'b0;
            endcase
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_accept) state_next = ST_EXEC;
            ST_EXEC: state_next = iter_go ? ST_ITER : ST_DONE;
            ST_ITER: if (iter_stat.done) state_next = ST_DONE;
            ST_DONE: if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath control and register updates
    always_comb begin
        s_tready        = (state_reg == ST_IDLE);
        mem_rd_en       = 1'b0;
        // entry just below the top, fetched while the instruction is latched
        mem_rd_addr     = AW'(count_reg - CW'(2));
        mem_wr_en       = 1'b0;
        mem_wr_addr     = AW'(count_reg - CW'(1));
        mem_wr_data     = top_reg;
        iter_ctrl.start  = iter_go;
        iter_ctrl.is_div = (cmd_reg != CMD_MUL);
        cmd_next        = cmd_reg;
        val_next        = val_reg;
        status_next     = status_reg;
        emit_valid_next = emit_valid_reg;
        emitted_next    = emitted_reg;
        top_next        = top_reg;
        count_next      = count_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    mem_rd_en       = 1'b1;
                    cmd_next        = cmd_t'(s_tdata[CMD_W-1:0]);
                    val_next        = s_tdata[S_FIELD_W-1:CMD_W];
                    status_next     = STAT_OK;
                    emit_valid_next = 1'b0;
                    emitted_next    = '0;
                end
            end
            ST_EXEC: begin
                unique case (cmd_reg) inside
                    CMD_PUSH, CMD_DUP: begin
                        if (cmd_reg == CMD_DUP && empty) begin
                            status_next = STAT_UNDER;
                        end else if (full) begin
                            status_next = STAT_OVER;
                        end else begin
                            // old top sinks into the memory
                            mem_wr_en  = !empty;
                            count_next = count_reg + CW'(1);
                            if (cmd_reg == CMD_PUSH) begin
                                top_next = val_reg;
                            end
                        end
                    end
                    CMD_DROP, CMD_EMIT: begin
                        if (empty) begin
                            status_next = STAT_UNDER;
                        end else begin
                            count_next = count_reg - CW'(1);
                            top_next   = below_two ? '0 : mem_rd_data;
                            if (cmd_reg == CMD_EMIT) begin
                                emit_valid_next = 1'b1;
                                emitted_next    = top_reg;
                            end
                        end
                    end
                    CMD_SWAP: begin
                        if (below_two) begin
                            status_next = STAT_UNDER;
                        end else begin
                            mem_wr_en   = 1'b1;
                            mem_wr_addr = AW'(count_reg - CW'(2));
                            top_next    = mem_rd_data;
                        end
                    end
                    CMD_ADD, CMD_SUB, CMD_EQ, CMD_NEQ: begin
                        if (below_two) begin
                            status_next = STAT_UNDER;
                        end else begin
                            count_next = count_reg - CW'(1);
                            unique case (cmd_reg)
                                CMD_ADD: top_next = mem_rd_data + top_reg;
                                CMD_SUB: top_next = mem_rd_data - top_reg;
                                CMD_EQ:  top_next = DATA_W'(mem_rd_data == top_reg);
                                default: top_next = DATA_W'(mem_rd_data != top_reg);
                            endcase
                        end
                    end
                    CMD_MUL, CMD_DIV, CMD_MOD: begin
                        if (below_two) begin
                            status_next = STAT_UNDER;
                        end else if (cmd_reg != CMD_MUL && top_zero) begin
                            status_next = STAT_DIVZ;
                        end
                    end
                    // unknown codes do nothing and report ok
                    default: ;
                endcase
            end
            ST_ITER: begin
                if (iter_stat.done) begin
                    count_next = count_reg - CW'(1);
                    top_next   = (cmd_reg == CMD_DIV) ? iter_quot : iter_acc;
                end
            end
            ST_DONE: ;
            default: ;
        endcase
    end

    // output register, refilled only once the previous beat has gone
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {{M_PAD_W{1'b0}}, DEPTH_W'(count_reg), top_reg, emitted_reg,
                             emit_valid_reg, status_reg};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            top_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            top_reg      <= top_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        val_reg        <= val_next;
        status_reg     <= status_next;
        emit_valid_reg <= emit_valid_next;
        emitted_reg    <= emitted_next;
        m_tdata_reg    <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // entries below the top of stack
    sma_stack_mem #(
        .DEPTH (STACK_DEPTH)
    ) u_stack_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // shared multiply / divide unit: a is the entry below the top, b the top
    sma_iter_unit u_iter_unit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (iter_ctrl),
        .opa     (mem_rd_data),
        .opb     (top_reg),
        .stat    (iter_stat),
        .acc     (iter_acc),
        .quot    (iter_quot)
    );

endmodule

`default_nettype wire

FILE: hdl/sma_stack_mem.sv
`default_nettype none

module sma_stack_mem #(
    parameter int DEPTH = 2
) (
    input  logic                                aclk,
    input  logic                                wr_en,
    input  logic [$clog2(DEPTH)-1:0]            wr_addr,
    input  logic [sma_pkg::DATA_W-1:0]          wr_data,
    input  logic                                rd_en,
    input  logic [$clog2(DEPTH)-1:0]            rd_addr,
    output logic [sma_pkg::DATA_W-1:0]          rd_data
);
    import sma_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/sma_iter_unit.sv
`default_nettype none

module sma_iter_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  sma_pkg::iter_ctrl_t           ctrl,
    input  logic [sma_pkg::DATA_W-1:0]    opa,
    input  logic [sma_pkg::DATA_W-1:0]    opb,
    output sma_pkg::iter_stat_t           stat,
    output logic [sma_pkg::DATA_W-1:0]    acc,
    output logic [sma_pkg::DATA_W-1:0]    quot
);
    import sma_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              is_div_reg, is_div_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic [DATA_W-1:0] sh_reg, sh_next;     // multiplicand, or dividend/quotient
    logic [DATA_W-1:0] op_reg, op_next;     // multiplier, or divisor

    logic [DATA_W:0]   rem_sh;
    logic [DATA_W+1:0] add_x, add_y, add_sum;
    logic              add_cin;

    // one shared adder: accumulate for multiply, trial subtract for divide
    always_comb begin
        rem_sh = {acc_reg, sh_reg[DATA_W-1]};
        if (is_div_reg) begin
            add_x   = {1'b0, rem_sh};
            add_y   = ~{2'b00, op_reg};
            add_cin = 1'b1;
        end else begin
            add_x   = {2'b00, acc_reg};
            add_y   = op_reg[0] ? {2'b00, sh_reg} : '0;
            add_cin = 1'b0;
        end
        add_sum = add_x + add_y + {{(DATA_W+1){1'b0}}, add_cin};
    end

    always_comb begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        is_div_next = is_div_reg;
        step_next   = step_reg;
        acc_next    = acc_reg;
        sh_next     = sh_reg;
        op_next     = op_reg;
        if (ctrl.start) begin
            busy_next   = 1'b1;
            is_div_next = ctrl.is_div;
            step_next   = '0;
            acc_next    = '0;
            sh_next     = opa;
            op_next     = opb;
        end else if (busy_reg) begin
            step_next = step_reg + STEP_W'(1);
            if (step_reg == '1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            if (is_div_reg) begin
                if (!add_sum[DATA_W+1]) begin
                    acc_next = add_sum[DATA_W-1:0];
                    sh_next  = {sh_reg[DATA_W-2:0], 1'b1};
                end else begin
                    acc_next = rem_sh[DATA_W-1:0];
                    sh_next  = {sh_reg[DATA_W-2:0], 1'b0};
                end
            end else begin
                acc_next = add_sum[DATA_W-1:0];
                sh_next  = {sh_reg[DATA_W-2:0], 1'b0};
                op_next  = {1'b0, op_reg[DATA_W-1:1]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        is_div_reg <= is_div_next;
        step_reg   <= step_next;
        acc_reg    <= acc_next;
        sh_reg     <= sh_next;
        op_reg     <= op_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign acc       = acc_reg;
    assign quot      = sh_reg;

endmodule

`default_nettype wire
